// File: rtl/frustum_sphere_culling_core_assert.svh
// Assertion macros for the frustum sphere culling core.
// Used by the core RTL file, which checks its own sequencing; no dependencies.
`ifndef FRUSTUM_SPHERE_CULLING_CORE_ASSERT_SVH
`define FRUSTUM_SPHERE_CULLING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define FSC_ASSERT(lbl, prop, msg)
`define FSC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/fsc_pkg.sv
// Package for the frustum sphere culling core: sizes, codes and item types.
// No dependencies.
`default_nettype none
package fsc_pkg;
  localparam int NUM_PLANES = 6;
  localparam int FRAC_BITS = 16;
  localparam int NORM_BITS = 30;
  localparam int SHIFT_MAX = (NORM_BITS > FRAC_BITS) ? NORM_BITS : FRAC_BITS;
  localparam int DIV_W = 32 + SHIFT_MAX;
  localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  localparam logic [1:0] VERDICT_INSIDE = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE = 2'd2;

  typedef struct packed {
    logic mode;
    logic [2:0] plane_index;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] offset;
  } plane_t;
endpackage
`default_nettype wire

// File: rtl/fsc_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on fsc_pkg.
`default_nettype none
interface fsc_in_if;
  import fsc_pkg::*;
  logic valid;
  logic ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface fsc_out_if;
  import fsc_pkg::*;
  logic valid;
  logic ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: rtl/frustum_sphere_culling_core.sv
// Frustum sphere culling core: holds NUM_PLANES normalized clip planes and
// classifies spheres against them. A test uses the single shared 32x32
// multiplier, which forms three products per plane in turn. A plane load
// uses the bit-serial square root and the bit-serial divider, which
// normalizes the four coefficients one after another. One item is in work
// at a time; input ready is low meanwhile.
`default_nettype none
`include "frustum_sphere_culling_core_assert.svh"
module frustum_sphere_culling_core (
  input logic clk,
  input logic rst,
  fsc_in_if.sink in_ch,
  fsc_out_if.source out_ch
);
  import fsc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SQ      = 8'b0000_0010,
    S_ROOT_GO = 8'b0000_0100,
    S_ROOT    = 8'b0000_1000,
    S_DIV_GO  = 8'b0001_0000,
    S_DIV     = 8'b0010_0000,
    S_DOT     = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  state_t state;
  logic [2:0] cnt;
  logic [PLANE_W-1:0] pidx;
  in_item_t item;
  logic signed [65:0] acc;
  logic signed [63:0] prod;
  logic mul_vld;
  logic [31:0] len;
  logic signed [31:0] tmp_nx, tmp_ny, tmp_nz;
  plane_t planes [NUM_PLANES];
  logic any_out, any_int, deg;
  logic out_valid;
  out_item_t out_item;

  logic signed [31:0] mul_a, mul_b;
  logic mul_go;
  logic signed [31:0] div_coef;
  logic [31:0] div_mag;
  logic [DIV_W-1:0] div_dividend;
  logic div_start, div_done;
  logic [DIV_W-1:0] div_q;
  logic sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic signed [31:0] q_signed;
  logic signed [31:0] q_sat;
  logic signed [65:0] acc_sh;
  logic signed [37:0] plane_dist, rpos, rneg;
  logic load_ok;
  logic [PLANE_W-1:0] load_idx;
  plane_t cur;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.item = out_item;

  assign cur = planes[pidx];
  assign load_idx = PLANE_W'(item.plane_index);
  assign load_ok = 32'(item.plane_index) < NUM_PLANES;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      unique case (cnt)
        3'd0: begin mul_a = item.coef_a; mul_b = item.coef_a; end
        3'd1: begin mul_a = item.coef_b; mul_b = item.coef_b; end
        3'd2: begin mul_a = item.coef_c; mul_b = item.coef_c; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      unique case (cnt)
        3'd0: begin mul_a = cur.nx; mul_b = item.center_x; end
        3'd1: begin mul_a = cur.ny; mul_b = item.center_y; end
        3'd2: begin mul_a = cur.nz; mul_b = item.center_z; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_go = ((state == S_SQ) || (state == S_DOT)) && (cnt < 3'd3);

  always_comb begin
    unique case (cnt)
      3'd0: div_coef = item.coef_a;
      3'd1: div_coef = item.coef_b;
      3'd2: div_coef = item.coef_c;
      default: div_coef = item.coef_d;
    endcase
  end
  assign div_mag = div_coef[31] ? (~div_coef + 32'd1) : div_coef;
  assign div_dividend = (cnt == 3'd3) ? (DIV_W'(div_mag) << FRAC_BITS)
                                      : (DIV_W'(div_mag) << NORM_BITS);
  assign div_start = (state == S_DIV_GO);
  assign sqrt_start = (state == S_ROOT_GO) && (acc != '0) && load_ok;

  assign q_signed = div_coef[31] ? (~div_q[31:0] + 32'd1) : div_q[31:0];
  always_comb begin
    if (!div_coef[31]) begin
      q_sat = (div_q > DIV_W'(33'h0_7fff_ffff)) ? 32'sh7fff_ffff : div_q[31:0];
    end else begin
      q_sat = (div_q > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                : (~div_q[31:0] + 32'd1);
    end
  end

  assign acc_sh = acc >>> NORM_BITS;
  assign plane_dist = acc_sh[37:0] + {{6{cur.offset[31]}}, cur.offset};
  assign rpos = {7'd0, item.radius};
  assign rneg = -rpos;

  fsc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .value(acc[63:0]),
    .done(sqrt_done), .root(sqrt_root)
  );

  fsc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(len), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pidx <= '0;
      mul_vld <= 1'b0;
      out_valid <= 1'b0;
      any_out <= 1'b0;
      any_int <= 1'b0;
      deg <= 1'b0;
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else begin
      mul_vld <= mul_go;
      if (state == S_FIN && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cnt <= '0;
            pidx <= '0;
            any_out <= 1'b0;
            any_int <= 1'b0;
            deg <= 1'b0;
            state <= (in_ch.item.mode == MODE_TEST) ? S_DOT : S_SQ;
          end
        end
        S_SQ: begin
          if (cnt == 3'd3) begin
            state <= S_ROOT_GO;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_ROOT_GO: begin
          if (acc == '0) begin
            deg <= 1'b1;
            state <= S_FIN;
          end else if (!load_ok) begin
            state <= S_FIN;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            cnt <= '0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (cnt == 3'd3) begin
              planes[load_idx] <= '{nx: tmp_nx, ny: tmp_ny, nz: tmp_nz, offset: q_sat};
              state <= S_FIN;
            end else begin
              cnt <= cnt + 3'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_DOT: begin
          if (cnt == 3'd4) begin
            if (plane_dist < rneg) begin
              any_out <= 1'b1;
            end else if (plane_dist < rpos) begin
              any_int <= 1'b1;
            end
            cnt <= '0;
            if (32'(pidx) == NUM_PLANES - 1) begin
              state <= S_FIN;
            end else begin
              pidx <= pidx + 1'b1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      item <= in_ch.item;
    end
    if ((state == S_IDLE) || ((state == S_DOT) && (cnt == 3'd4))) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + 66'(prod);
    end
    if (state == S_ROOT && sqrt_done) begin
      len <= sqrt_root;
    end
    if (state == S_DIV && div_done) begin
      unique case (cnt)
        3'd0: tmp_nx <= q_signed;
        3'd1: tmp_ny <= q_signed;
        3'd2: tmp_nz <= q_signed;
        default: ;
      endcase
    end
    if (state == S_FIN && (!out_valid || out_ch.ready)) begin
      out_item.degenerate <= (item.mode == MODE_LOAD) && deg;
      if (item.mode == MODE_LOAD) begin
        out_item.verdict <= VERDICT_INSIDE;
      end else if (any_out) begin
        out_item.verdict <= VERDICT_OUTSIDE;
      end else if (any_int) begin
        out_item.verdict <= VERDICT_INTERSECT;
      end else begin
        out_item.verdict <= VERDICT_INSIDE;
      end
    end
  end

  `FSC_ASSERT_IMPL(a_div_done_in_div, div_done, state == S_DIV, "divider finished outside divide")
  `FSC_ASSERT_IMPL(a_root_done_in_root, sqrt_done, state == S_ROOT, "root finished outside root")
  `FSC_ASSERT_IMPL(a_out_from_fin, $rose(out_valid), $past(state == S_FIN), "result without finish")
  `FSC_ASSERT_IMPL(a_deg_inside, out_valid && out_item.degenerate, out_item.verdict == VERDICT_INSIDE, "degenerate load with verdict")
endmodule
`default_nettype wire

// File: rtl/fsc_isqrt.sv
// Bit-by-bit integer square root of a 64-bit value, one result bit per cycle.
// Depends on nothing outside this file.
`default_nettype none
module fsc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  logic busy;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value;
      res <= '0;
      bitm <= {2'b01, 62'd0};
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end
endmodule
`default_nettype wire

// File: rtl/fsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fsc_pkg for the dividend width.
`default_nettype none
module fsc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fsc_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]              divisor,
  output logic                     done,
  output logic [fsc_pkg::DIV_W-1:0] quotient
);
  import fsc_pkg::*;
  localparam int CNT_W = $clog2(DIV_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [DIV_W-1:0] qsh;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic ge;

  assign rem_sh = {rem, qsh[DIV_W-1]};
  assign ge = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign quotient = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      qsh <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      qsh <= {qsh[DIV_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire
